### rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// shared types and codes for the indexed list insert/remove block
// ----------------------------------------------------------------------------
package ilir_pkg;

  // command kinds (in_tuser)
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_RANGE  = 3'd2;
  localparam logic [2:0] KIND_GET    = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CLAMPED = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // what a decoded command needs from the datapath
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_GET,
    PLAN_MOVE,
    PLAN_INSERT
  } plan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_RD,
    S_GET_CAP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INS_WR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the input word
    logic plan_load;  // register the decoded plan
    logic rd_src;     // read the move source entry
    logic rd_pos;     // read the get position
    logic mv_write;   // write the moved entry, step pointers
    logic ins_write;  // write the inserted value
    logic get_cap;    // capture the read data
    logic finish;     // load the result register and commit the count
  } ilir_cmd_t;

  // datapath -> controller
  typedef struct packed {
    plan_t plan_dec;
    logic  moves_zero_dec;
    logic  last_move;
    logic  is_insert;
    logic  out_free;
  } ilir_stat_t;

endpackage

### rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// fixed-capacity ordered list with insert, remove, range remove, get, clear
// ----------------------------------------------------------------------------
// sequence: each accepted word is decoded; remove, range and insert move up
//   to DEPTH-1 entries one at a time, insert writes the value, get reads and
//   captures an entry, clear and rejected commands go straight to hand-off;
//   a new word is accepted only once its result is loaded; each moved entry
//   costs a read and a write on the single-port-pair entry ram
// reset: synchronous active-low rst_n empties the list and drops out_tvalid;
//   the entry ram is not cleared (entries past the count are never read)
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
  parameter int DEPTH  = 64,  // list capacity, 2 to 127
  parameter int DATA_W = 32   // stored entry width, 1 to 32
) (
  input  logic        clk,
  input  logic        rst_n,

  // command words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] kind
  input  logic [47:0] in_tdata,   // [6:0] index, [12:7] end_index, [44:13] value

  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [2:0] status, [34:3] read_value,
                                  // [41:35] count_after, [42] is_empty
);
  import ilir_pkg::*;

  ilir_cmd_t   cmd;
  ilir_stat_t  stat;

  logic [2:0]  res_status;
  logic [31:0] res_read_value;
  logic [6:0]  res_count_after;
  logic        res_is_empty;

  // sequencer: owns the input handshake and steps through entry moves
  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: decode, pointers, entry ram and the result register
  ilir_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_tuser),
    .in_index        (in_tdata[6:0]),
    .in_end_index    (in_tdata[12:7]),
    .in_value        (in_tdata[44:13]),
    .cmd             (cmd),
    .stat            (stat),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_status      (res_status),
    .out_read_value  (res_read_value),
    .out_count_after (res_count_after),
    .out_is_empty    (res_is_empty)
  );

  // pack the result fields, lowest field first, padded to whole bytes
  assign out_tdata = {5'd0, res_is_empty, res_count_after, res_read_value, res_status};

endmodule

### rtl/ilir_ram.sv
// ----------------------------------------------------------------------------
// ilir_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ilir_ctrl.sv
// ----------------------------------------------------------------------------
// ilir_ctrl
// command sequencer: decode, entry moves one at a time, result hand-off
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ilir_pkg::ilir_stat_t stat,
  output ilir_pkg::ilir_cmd_t  cmd
);
  import ilir_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.plan_load = 1'b1;
        unique case (stat.plan_dec)
          PLAN_NONE:   state_nxt = S_DONE;
          PLAN_GET:    state_nxt = S_GET_RD;
          PLAN_MOVE:   state_nxt = stat.moves_zero_dec ? S_DONE : S_MOVE_RD;
          PLAN_INSERT: state_nxt = stat.moves_zero_dec ? S_INS_WR : S_MOVE_RD;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_GET_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_MOVE_RD: begin
        cmd.rd_src = 1'b1;
        state_nxt  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.mv_write = 1'b1;
        if (stat.last_move) begin
          state_nxt = stat.is_insert ? S_INS_WR : S_DONE;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/ilir_dp.sv
// ----------------------------------------------------------------------------
// ilir_dp
// datapath: command decode, count, move pointers, entry ram, result register
// ----------------------------------------------------------------------------
module ilir_dp #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_kind,
  input  logic [6:0]           in_index,
  input  logic [5:0]           in_end_index,
  input  logic [31:0]          in_value,
  input  ilir_pkg::ilir_cmd_t  cmd,
  output ilir_pkg::ilir_stat_t stat,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [2:0]           out_status,
  output logic [31:0]          out_read_value,
  output logic [6:0]           out_count_after,
  output logic                 out_is_empty
);
  import ilir_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  // latched command
  logic [2:0]        kind_r;
  logic [6:0]        idx_r;
  logic [5:0]        last_r;
  logic [DATA_W-1:0] val_r;

  // list state and plan
  logic [CW-1:0] cnt_r, new_cnt_r, moves_r;
  logic [AW-1:0] src_r, dst_r, pos_r;
  logic          up_r;
  plan_t         plan_r;
  logic [2:0]    status_r;
  logic [31:0]   rd_value_r;

  // result register
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_rd_r;
  logic [CW-1:0] out_cnt_r;

  // decode
  logic [XW-1:0] idx_x, last_x, cnt_x, pos_x;
  plan_t         dec_plan;
  logic [2:0]    dec_status;
  logic [CW-1:0] dec_cnt, dec_moves;
  logic [AW-1:0] dec_src, dec_dst, dec_pos;
  logic          dec_up;

  logic [DATA_W-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  logic              ram_re, ram_we;

  always_comb begin
    idx_x  = XW'(idx_r);
    last_x = XW'(last_r);
    cnt_x  = XW'(cnt_r);
    pos_x  = (idx_x > cnt_x) ? cnt_x : idx_x;

    dec_plan   = PLAN_NONE;
    dec_status = ST_RANGE;
    dec_cnt    = cnt_r;
    dec_moves  = '0;
    dec_src    = '0;
    dec_dst    = '0;
    dec_pos    = '0;
    dec_up     = 1'b1;
    unique case (kind_r)
      KIND_INSERT: begin
        if (cnt_x == XW'(DEPTH)) begin
          dec_status = ST_FULL;
        end else begin
          dec_status = (idx_x > cnt_x) ? ST_CLAMPED : ST_OK;
          dec_plan   = PLAN_INSERT;
          dec_moves  = CW'(cnt_x - pos_x);
          dec_src    = AW'(cnt_x - XW'(1));
          dec_dst    = AW'(cnt_x);
          dec_pos    = AW'(pos_x);
          dec_up     = 1'b0;
          dec_cnt    = CW'(cnt_x + XW'(1));
        end
      end
      KIND_REMOVE: begin
        if (cnt_x == '0) begin
          dec_status = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_status = ST_OK;
          dec_plan   = PLAN_MOVE;
          dec_moves  = CW'(cnt_x - idx_x - XW'(1));
          dec_src    = AW'(idx_x + XW'(1));
          dec_dst    = AW'(idx_x);
          dec_cnt    = CW'(cnt_x - XW'(1));
        end
      end
      KIND_RANGE: begin
        if (cnt_x == '0) begin
          dec_status = ST_EMPTY;
        end else if (last_x >= cnt_x || idx_x > last_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_status = ST_OK;
          dec_plan   = PLAN_MOVE;
          dec_moves  = CW'(cnt_x - last_x - XW'(1));
          dec_src    = AW'(last_x + XW'(1));
          dec_dst    = AW'(idx_x);
          dec_cnt    = CW'(cnt_x - (last_x - idx_x + XW'(1)));
        end
      end
      KIND_GET: begin
        if (cnt_x == '0) begin
          dec_status = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_status = ST_OK;
          dec_plan   = PLAN_GET;
          dec_pos    = AW'(idx_x);
        end
      end
      KIND_CLEAR: begin
        dec_status = ST_OK;
        dec_cnt    = '0;
      end
      default: dec_status = ST_RANGE;
    endcase
  end

  // command capture, plan, move pointer and result data registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      idx_r  <= in_index;
      last_r <= in_end_index;
      val_r  <= DATA_W'(in_value);
    end
    if (cmd.plan_load) begin
      plan_r     <= dec_plan;
      status_r   <= dec_status;
      new_cnt_r  <= dec_cnt;
      moves_r    <= dec_moves;
      src_r      <= dec_src;
      dst_r      <= dec_dst;
      pos_r      <= dec_pos;
      up_r       <= dec_up;
      rd_value_r <= '0;
    end
    if (cmd.mv_write) begin
      moves_r <= moves_r - CW'(1);
      src_r   <= up_r ? src_r + AW'(1) : src_r - AW'(1);
      dst_r   <= up_r ? dst_r + AW'(1) : dst_r - AW'(1);
    end
    if (cmd.get_cap) begin
      rd_value_r <= 32'(ram_rdata);
    end
    if (cmd.finish) begin
      out_status_r <= status_r;
      out_rd_r     <= rd_value_r;
      out_cnt_r    <= new_cnt_r;
    end
  end

  // control state: count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        cnt_r <= new_cnt_r;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entry store
  assign ram_re    = cmd.rd_src | cmd.rd_pos;
  assign ram_raddr = cmd.rd_src ? src_r : pos_r;
  assign ram_we    = cmd.mv_write | cmd.ins_write;
  assign ram_waddr = cmd.mv_write ? dst_r : pos_r;
  assign ram_wdata = cmd.mv_write ? ram_rdata : val_r;

  ilir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign stat.plan_dec       = dec_plan;
  assign stat.moves_zero_dec = (dec_moves == '0);
  assign stat.last_move      = (moves_r == CW'(1));
  assign stat.is_insert      = (plan_r == PLAN_INSERT);
  assign stat.out_free       = !out_valid_r || out_tready;

  assign out_tvalid      = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rd_r;
  assign out_count_after = 7'(out_cnt_r);
  assign out_is_empty    = (out_cnt_r == '0);

endmodule
